[design/w512_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the state-advance function for the WELL512a generator.
// No dependencies; every other design file imports this package.
package w512_pkg;

	localparam int POOL_DEPTH = 16;
	localparam int SLOT_W     = 4;
	localparam int WORD_W     = 32;
	localparam int VALUE_W    = 53;
	localparam int LOW_W      = 21;

	localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda44_2d24;

	typedef enum logic [1:0] {
		MODE_WORD = 2'd0,
		MODE_FRAC = 2'd1,
		MODE_SEED = 2'd2
	} mode_t;

	// One command beat as held in the input register
	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] seed_index;
		logic [WORD_W-1:0] seed_value;
	} cmd_t;

	// Pool kept rotated so that entry 0 is always the word at the current position
	typedef logic [POOL_DEPTH-1:0][WORD_W-1:0] pool_t;

	typedef struct packed {
		pool_t             pool;
		logic [WORD_W-1:0] word;
	} adv_t;

	// One step of the recurrence on the rotated pool. The position moves back by one,
	// which in rotated form is a shift up by one entry with the new word at entry 0.
	function automatic adv_t w512_advance(input pool_t r);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c2;
		logic [WORD_W-1:0] na;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] old;
		logic [WORD_W-1:0] z;
		adv_t res;
		a   = r[0];
		c   = r[13];
		b   = a ^ c ^ (a << 16) ^ (c << 15);
		c2  = r[9] ^ (r[9] >> 11);
		na  = b ^ c2;
		d   = na ^ ((na << 5) & TEMPER_MASK);
		old = r[POOL_DEPTH-1];
		z   = old ^ b ^ d ^ (old << 2) ^ (b << 18) ^ (c2 << 28);
		res.pool[0] = z;
		res.pool[1] = na;
		for (int k = 2; k < POOL_DEPTH; k++) begin
			res.pool[k] = r[k-1];
		end
		res.word = z;
		return res;
	endfunction

endpackage

[design/w512_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command beats in, random value beats out.
// Widths follow w512_pkg.
interface w512_cmd_if;
	import w512_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [SLOT_W-1:0] seed_index;
	logic [WORD_W-1:0] seed_value;

	modport source (output valid, output mode, output seed_index, output seed_value,
		input ready);
	modport sink (input valid, input mode, input seed_index, input seed_value,
		output ready);
endinterface

interface w512_rnd_if;
	import w512_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

[design/w512_pool.sv]
`timescale 1ns / 1ps
// State pool of the generator: sixteen rotated words, the position and one or two advances.
// Depends on w512_pkg.
module w512_pool
	import w512_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  cmd_t               cmd,
	output logic [VALUE_W-1:0] value
);

	pool_t             pool_q;
	logic [SLOT_W-1:0] pos_q;
	adv_t              adv1;
	adv_t              adv2;
	logic [SLOT_W-1:0] seed_slot;

	always_comb begin
		adv1      = w512_advance(pool_q);
		adv2      = w512_advance(adv1.pool);
		// map the absolute seed index onto the rotated pool
		seed_slot = cmd.seed_index - pos_q;
		if (cmd.mode == MODE_FRAC) begin
			value = {adv1.word, adv2.word[LOW_W-1:0]};
		end else begin
			value = {{(VALUE_W-WORD_W){1'b0}}, adv1.word};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= '0;
			pos_q  <= '0;
		end else if (fire) begin
			case (cmd.mode)
				MODE_WORD: begin
					pool_q <= adv1.pool;
					pos_q  <= pos_q - SLOT_W'(1);
				end
				MODE_FRAC: begin
					pool_q <= adv2.pool;
					pos_q  <= pos_q - SLOT_W'(2);
				end
				MODE_SEED: begin
					pool_q[seed_slot] <= cmd.seed_value;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/well512a_generator.sv]
`timescale 1ns / 1ps
// WELL512a generator, top level: input register, pool and result register.
// Depends on w512_pkg, w512_if and w512_pool.
//
// Usage:
//   cmd carries one command per beat: mode 0 draws a 32-bit word, mode 1 draws a
//   53-bit fraction numerator (divide by 2^53 in software), mode 2 writes seed_value
//   into pool word seed_index. Mode 3 does nothing. Seed writes give no result beat.
//   rnd carries one value per draw, in command order.
//   A draw is held in the input register, then its value is written into the result
//   register, which drives rnd.
//   Throughput: one command per cycle while rnd does not stall; the two advances
//   of the recurrence for a mode 1 draw are done within that cycle.
//   Reset clears the pool and the position to zero; an all-zero pool only ever
//   yields zero, so seed all sixteen words before drawing.
//   When rnd stalls, the result register holds its value and a pending draw waits
//   in the input register; cmd.ready drops only once both are occupied. Seed
//   writes behind a stalled result still complete.
module well512a_generator
	import w512_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	w512_cmd_if.sink   cmd,
	w512_rnd_if.source rnd
);

	logic               v_s1;
	cmd_t               cmd_s1;
	logic               res_s1;
	logic               fire_s1;
	logic               take;
	logic               rnd_valid_q;
	logic [VALUE_W-1:0] rnd_value_q;
	logic [VALUE_W-1:0] value;

	always_comb begin
		res_s1    = v_s1 && (cmd_s1.mode == MODE_WORD || cmd_s1.mode == MODE_FRAC);
		fire_s1   = v_s1 && (!res_s1 || !rnd_valid_q || rnd.ready);
		cmd.ready = !v_s1 || fire_s1;
		take      = cmd.valid && cmd.ready;
		rnd.valid = rnd_valid_q;
		rnd.value = rnd_value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (fire_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.mode       <= cmd.mode;
			cmd_s1.seed_index <= cmd.seed_index;
			cmd_s1.seed_value <= cmd.seed_value;
		end
	end

	w512_pool u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.cmd    (cmd_s1),
		.value  (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_valid_q <= 1'b0;
		end else if (fire_s1 && res_s1) begin
			rnd_valid_q <= 1'b1;
		end else if (rnd.ready) begin
			rnd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_s1) begin
			rnd_value_q <= value;
		end
	end

	// never overwrite a result beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rnd_valid_q && !rnd.ready) |-> !(fire_s1 && res_s1))
		else $error("result register overwritten while stalled");

	// an empty input register always takes a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> cmd.ready)
		else $error("input register empty but not ready");

	// seed writes never produce a result
	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && cmd_s1.mode == MODE_SEED) |=> !$rose(rnd_valid_q))
		else $error("seed write produced a result beat");

	// a word draw leaves the upper bits clear
	a_word_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && cmd_s1.mode == MODE_WORD) |=> rnd_value_q[VALUE_W-1:WORD_W] == '0)
		else $error("word draw has upper bits set");

endmodule
